@@ rtl/psu_pkg.sv @@
package psu_pkg;

    // Filter type codes carried by the first byte of each row
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filt_t;

    // Configuration register indexes
    localparam logic REG_ROW_BYTES = 1'b0;
    localparam logic REG_BPP       = 1'b1;

    localparam int CFG_DW = 14;
    localparam int RB_W   = 14;
    localparam int BPP_W  = 4;

    // Per-byte control that travels with a data byte into the reconstruct stage
    typedef struct packed {
        filt_t filter;
        logic  first_row;
        logic  has_left;
        logic  row_end;
    } item_ctl_t;

endpackage

@@ rtl/psu_ram.sv @@
module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/psu_history.sv @@
module psu_history #(
    parameter int MAX_PIXEL_BYTES = 8,
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic          aclk,
    input  logic          shift_en,
    input  logic [7:0]    left_in,
    input  logic [7:0]    up_in,
    input  logic [SW-1:0] sel,
    output logic [7:0]    left_out,
    output logic [7:0]    upleft_out
);

    logic [7:0] left_reg [MAX_PIXEL_BYTES];
    logic [7:0] upl_reg  [MAX_PIXEL_BYTES];

    // Advance both histories by one byte per reconstructed byte
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            left_reg[0] <= left_in;
            upl_reg[0]  <= up_in;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
                left_reg[i] <= left_reg[i-1];
                upl_reg[i]  <= upl_reg[i-1];
            end
        end
    end

    // Tap the byte one pixel back
    assign left_out   = left_reg[sel];
    assign upleft_out = upl_reg[sel];

endmodule

@@ rtl/psu_predict.sv @@
module psu_predict (
    input  psu_pkg::item_ctl_t ctl,
    input  logic [7:0]         data_byte,
    input  logic [7:0]         left_hist,
    input  logic [7:0]         upleft_hist,
    input  logic [7:0]         up_mem,
    output logic [7:0]         up_byte,
    output logic [7:0]         recon_byte
);

    logic [7:0]       a;
    logic [7:0]       b;
    logic [7:0]       c;
    logic [8:0]       sum_ab;
    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_abc;
    logic [9:0]       pa;
    logic [9:0]       pb;
    logic [9:0]       pc;
    logic [7:0]       paeth;
    logic [7:0]       pred;

    // Neighbors; missing ones read as zero
    assign b = ctl.first_row ? 8'd0 : up_mem;
    assign a = ctl.has_left ? left_hist : 8'd0;
    assign c = ctl.has_left ? upleft_hist : 8'd0;
    assign up_byte = b;

    assign sum_ab = {1'b0, a} + {1'b0, b};

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    assign d_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
    assign d_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
    assign d_abc = $signed({1'b0, sum_ab}) - $signed({1'b0, c, 1'b0});
    assign pa = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
    assign pb = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
    assign pc = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

    always_comb begin
        if (pa <= pb && pa <= pc) begin
            paeth = a;
        end else if (pb <= pc) begin
            paeth = b;
        end else begin
            paeth = c;
        end
    end

    // Select predictor by row filter
    always_comb begin
        case (ctl.filter)
            psu_pkg::FILT_SUB:   pred = a;
            psu_pkg::FILT_UP:    pred = b;
            psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
            psu_pkg::FILT_PAETH: pred = paeth;
            default:             pred = 8'd0;
        endcase
    end

    assign recon_byte = data_byte + pred;

endmodule

@@ rtl/png_scanline_unfilter_core.sv @@
// An accepted data byte is registered in the reconstruct stage, then in the output register.
// Throughput: one byte per cycle while m_tready does not stall the output, set by
// the left-neighbor loop through the reconstruct stage and the line buffer's single write and read port.
// Filter bytes take one transfer and give no output.
// Reset (aresetn low, synchronous) clears control and sets row_bytes and
// bytes_per_pixel to 1; the line buffer is not cleared.
module png_scanline_unfilter_core #(
    parameter int MAX_ROW_BYTES   = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [13:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] new_image
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] recon_byte
    output logic        m_tlast     // row_end
);

    localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int EW = (AW + 1 > psu_pkg::RB_W) ? AW + 1 : psu_pkg::RB_W;
    localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // Configuration
    logic [psu_pkg::RB_W-1:0]  rb_reg;
    logic [psu_pkg::BPP_W-1:0] bpp_reg;
    logic [EW-1:0]             rb_eff;
    logic [psu_pkg::BPP_W-1:0] bpp_eff;

    // Row tracking
    logic                      expect_filter_reg;
    logic                      expect_filter_next;
    logic [AW-1:0]             x_reg;
    logic [AW-1:0]             x_next;
    logic                      first_row_reg;
    logic                      first_row_next;
    psu_pkg::filt_t            row_filter_reg;
    psu_pkg::filt_t            row_filter_next;

    // Reconstruct stage
    logic                      s1_valid_reg;
    logic [7:0]                s1_byte_reg;
    logic [AW-1:0]             s1_x_reg;
    psu_pkg::item_ctl_t        s1_ctl_reg;
    psu_pkg::item_ctl_t        ctl_in;

    // Output register
    logic                      m_valid_reg;
    logic [7:0]                m_data_reg;
    logic                      m_last_reg;

    logic                      s_xfer;
    logic                      is_filter;
    logic                      data_xfer;
    logic                      s1_adv;
    logic [EW-1:0]             x_plus1;
    logic                      row_end;
    logic [7:0]                up_mem;
    logic [7:0]                up_byte;
    logic [7:0]                recon;
    logic [7:0]                left_hist;
    logic [7:0]                upleft_hist;
    logic [SW-1:0]             bpp_sel;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rb_reg  <= psu_pkg::RB_W'(1);
            bpp_reg <= psu_pkg::BPP_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                psu_pkg::REG_ROW_BYTES: rb_reg  <= cfg_wdata;
                psu_pkg::REG_BPP:       bpp_reg <= cfg_wdata[psu_pkg::BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp registers into their working ranges
    always_comb begin
        if (rb_reg == '0) begin
            rb_eff = EW'(1);
        end else if (EW'(rb_reg) > EW'(MAX_ROW_BYTES)) begin
            rb_eff = EW'(MAX_ROW_BYTES);
        end else begin
            rb_eff = EW'(rb_reg);
        end
        if (bpp_reg == '0) begin
            bpp_eff = psu_pkg::BPP_W'(1);
        end else if (bpp_reg > psu_pkg::BPP_W'(MAX_PIXEL_BYTES)) begin
            bpp_eff = psu_pkg::BPP_W'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = bpp_reg;
        end
    end

    assign bpp_sel = SW'(bpp_eff - psu_pkg::BPP_W'(1));

    // Handshake
    assign s1_adv    = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign s_xfer    = s_tvalid && s_tready;
    assign is_filter = s_tuser || expect_filter_reg;
    assign data_xfer = s_xfer && !is_filter;

    assign x_plus1 = EW'(x_reg) + EW'(1);
    assign row_end = (x_plus1 >= rb_eff);

    // Row position update on each input transfer
    always_comb begin
        expect_filter_next = expect_filter_reg;
        x_next             = x_reg;
        first_row_next     = first_row_reg;
        row_filter_next    = row_filter_reg;
        if (s_xfer) begin
            if (is_filter) begin
                row_filter_next    = (s_tdata <= 8'(psu_pkg::FILT_PAETH))
                                   ? psu_pkg::filt_t'(s_tdata[2:0]) : psu_pkg::FILT_NONE;
                expect_filter_next = 1'b0;
                x_next             = '0;
                if (s_tuser) begin
                    first_row_next = 1'b1;
                end
            end else if (row_end) begin
                expect_filter_next = 1'b1;
                x_next             = '0;
                first_row_next     = 1'b0;
            end else begin
                x_next = x_plus1[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_filter_reg <= 1'b1;
            x_reg             <= '0;
            first_row_reg     <= 1'b1;
            row_filter_reg    <= psu_pkg::FILT_NONE;
        end else begin
            expect_filter_reg <= expect_filter_next;
            x_reg             <= x_next;
            first_row_reg     <= first_row_next;
            row_filter_reg    <= row_filter_next;
        end
    end

    // Control captured with a data byte
    assign ctl_in.filter    = row_filter_reg;
    assign ctl_in.first_row = first_row_reg;
    assign ctl_in.has_left  = (EW'(x_reg) >= EW'(bpp_eff));
    assign ctl_in.row_end   = row_end;

    // Load the reconstruct stage; line buffer read is issued alongside
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (data_xfer) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_xfer) begin
            s1_byte_reg <= s_tdata;
            s1_x_reg    <= x_reg;
            s1_ctl_reg  <= ctl_in;
        end
    end

    // Previous row line buffer
    psu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_buf (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_x_reg),
        .wdata (recon),
        .re    (data_xfer),
        .raddr (x_reg),
        .rdata (up_mem)
    );

    // Left and upper-left histories
    psu_history #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_history (
        .aclk       (aclk),
        .shift_en   (s1_adv),
        .left_in    (recon),
        .up_in      (up_byte),
        .sel        (bpp_sel),
        .left_out   (left_hist),
        .upleft_out (upleft_hist)
    );

    // Filter reconstruction
    psu_predict u_predict (
        .ctl         (s1_ctl_reg),
        .data_byte   (s1_byte_reg),
        .left_hist   (left_hist),
        .upleft_hist (upleft_hist),
        .up_mem      (up_mem),
        .up_byte     (up_byte),
        .recon_byte  (recon)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= recon;
            m_last_reg <= s1_ctl_reg.row_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
